// ===== rtl/pscc_pkg.sv =====
// ----------------------------------------------------------------------------
// pscc_pkg
// Shared widths, controller state type and command/status structs for the
// power-sum coprime check.
// ----------------------------------------------------------------------------
package pscc_pkg;

  localparam int BASE_WIDTH = 32;
  localparam int WORD_WIDTH = 64;
  localparam int EXP_WIDTH  = 6;
  localparam int HALF_WIDTH = WORD_WIDTH / 2;
  localparam int MCNT_WIDTH = 2;
  localparam int DCNT_WIDTH = $clog2(WORD_WIDTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POW_INIT,
    ST_POW_SQ,
    ST_POW_MUL,
    ST_POW_NEXT,
    ST_SUM,
    ST_GCD_INIT,
    ST_GCD_TEST,
    ST_GCD_DIV,
    ST_GCD_SWAP,
    ST_DONE
  } state_t;

  // Multiplier operand choice for the power step.
  typedef enum logic [0:0] {
    MOP_SQUARE,
    MOP_BASE
  } mop_t;

  typedef struct packed {
    logic       load;       // capture the input tuple
    logic       pow_init;   // start a power: acc <= 1
    logic [1:0] pow_sel;    // which base/exponent
    logic       mul_start;  // begin a checked multiply
    mop_t       mop;
    logic       pow_store;  // store acc into the selected power
    logic       sum;        // add the first two powers and compare
    logic       gcd_init;   // load the selected pair into p, q
    logic [1:0] gcd_sel;
    logic       div_start;  // begin p mod q
    logic       gcd_swap;   // p <= q, q <= r
    logic       gcd_store;  // record whether p equals one
    logic       done;       // drive the result strobe
  } cmd_t;

  typedef struct packed {
    logic exp_bit;   // selected exponent bit
    logic mul_busy;
    logic div_busy;
    logic q_zero;
  } stat_t;

endpackage

// ===== rtl/pscc_mul.sv =====
// ----------------------------------------------------------------------------
// pscc_mul
// Overflow-checked WORD_WIDTH product from four 32x32 partial products.
// ----------------------------------------------------------------------------
module pscc_mul (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pscc_pkg::WORD_WIDTH-1:0] a,
  input  logic [pscc_pkg::WORD_WIDTH-1:0] b,
  output logic                           busy,
  output logic [pscc_pkg::WORD_WIDTH-1:0] prod,
  output logic                           ovf
);
  import pscc_pkg::*;

  localparam int H = HALF_WIDTH;

  logic [WORD_WIDTH-1:0]   opa;
  logic [WORD_WIDTH-1:0]   opb;
  logic [MCNT_WIDTH-1:0]   step;
  logic [2*WORD_WIDTH-1:0] accum;
  logic [H-1:0]            pa;
  logic [H-1:0]            pb;
  logic [WORD_WIDTH-1:0]   part;
  logic [2*WORD_WIDTH-1:0] shifted;

  // Select the half-words for this step.
  always_comb begin
    pa = step[0] ? opa[WORD_WIDTH-1:H] : opa[H-1:0];
    pb = step[1] ? opb[WORD_WIDTH-1:H] : opb[H-1:0];
    part = WORD_WIDTH'(pa) * WORD_WIDTH'(pb);
    shifted = (2*WORD_WIDTH)'(part) << (H * (32'(step[0]) + 32'(step[1])));
  end

  // Accumulate one partial product per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      step  <= '0;
      opa   <= a;
      opb   <= b;
      accum <= '0;
    end else if (busy) begin
      accum <= accum + shifted;
      step  <= step + MCNT_WIDTH'(1);
      if (step == MCNT_WIDTH'(3)) begin
        busy <= 1'b0;
      end
    end
  end

  assign prod = accum[WORD_WIDTH-1:0];
  assign ovf  = |accum[2*WORD_WIDTH-1:WORD_WIDTH];

endmodule

// ===== rtl/pscc_div.sv =====
// ----------------------------------------------------------------------------
// pscc_div
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pscc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pscc_pkg::WORD_WIDTH-1:0] dividend,
  input  logic [pscc_pkg::WORD_WIDTH-1:0] divisor,
  output logic                           busy,
  output logic [pscc_pkg::WORD_WIDTH-1:0] rem
);
  import pscc_pkg::*;

  logic [WORD_WIDTH-1:0] num;
  logic [WORD_WIDTH-1:0] den;
  logic [DCNT_WIDTH-1:0] cnt;
  logic [WORD_WIDTH:0]   trial;
  logic [WORD_WIDTH:0]   diff;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    trial = {rem, num[WORD_WIDTH-1]};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DCNT_WIDTH'(WORD_WIDTH);
      num  <= dividend;
      den  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      num <= num << 1;
      rem <= diff[WORD_WIDTH] ? trial[WORD_WIDTH-1:0] : diff[WORD_WIDTH-1:0];
      cnt <= cnt - DCNT_WIDTH'(1);
      if (cnt == DCNT_WIDTH'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/pscc_datapath.sv =====
// ----------------------------------------------------------------------------
// pscc_datapath
// Operand registers, power accumulator, GCD registers and result flags.
// ----------------------------------------------------------------------------
module pscc_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  pscc_pkg::cmd_t                  cmd,
  input  logic [2:0]                      bit_idx,
  input  logic [pscc_pkg::BASE_WIDTH-1:0] base_a,
  input  logic [pscc_pkg::EXP_WIDTH-1:0]  exp_x,
  input  logic [pscc_pkg::BASE_WIDTH-1:0] base_b,
  input  logic [pscc_pkg::EXP_WIDTH-1:0]  exp_y,
  input  logic [pscc_pkg::BASE_WIDTH-1:0] base_c,
  input  logic [pscc_pkg::EXP_WIDTH-1:0]  exp_z,
  output pscc_pkg::stat_t                 stat,
  output logic                            done,
  output logic                            equation_holds,
  output logic                            pairwise_coprime,
  output logic                            counterexample,
  output logic                            overflow
);
  import pscc_pkg::*;

  logic [BASE_WIDTH-1:0] ra, rb, rc;
  logic [EXP_WIDTH-1:0]  rx, ry, rz;
  logic [WORD_WIDTH-1:0] acc, base_sel, pa, pb, pc;
  logic [EXP_WIDTH-1:0]  exp_sel;
  logic                  ovf, cop, eq;
  logic [WORD_WIDTH-1:0] p, q;
  logic [WORD_WIDTH:0]   sum_full;
  logic                  mul_busy, mul_ovf, mul_pend;
  logic [WORD_WIDTH-1:0] mul_b, prod;
  logic                  div_busy;
  logic [WORD_WIDTH-1:0] rem;

  // Pick base and exponent of the current power.
  always_comb begin
    case (cmd.pow_sel)
      2'd0:    begin base_sel = WORD_WIDTH'(ra); exp_sel = rx; end
      2'd1:    begin base_sel = WORD_WIDTH'(rb); exp_sel = ry; end
      default: begin base_sel = WORD_WIDTH'(rc); exp_sel = rz; end
    endcase
    mul_b    = (cmd.mop == MOP_BASE) ? base_sel : acc;
    sum_full = {1'b0, pa} + {1'b0, pb};
  end

  pscc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (acc),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (prod),
    .ovf   (mul_ovf)
  );

  pscc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (p),
    .divisor  (q),
    .busy     (div_busy),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      mul_pend <= 1'b0;
    end else begin
      done <= cmd.done;
      // Capture the tuple.
      if (cmd.load) begin
        ra <= base_a; rb <= base_b; rc <= base_c;
        rx <= exp_x;  ry <= exp_y;  rz <= exp_z;
        ovf <= 1'b0;
        cop <= 1'b1;
        eq  <= 1'b0;
      end
      if (cmd.pow_init) begin
        acc <= WORD_WIDTH'(1);
      end
      // Take the product when the multiplier finishes.
      if (cmd.mul_start) begin
        mul_pend <= 1'b1;
      end else if (mul_pend && !mul_busy) begin
        mul_pend <= 1'b0;
        acc      <= prod;
        if (mul_ovf) begin
          ovf <= 1'b1;
        end
      end
      if (cmd.pow_store) begin
        case (cmd.pow_sel)
          2'd0:    pa <= acc;
          2'd1:    pb <= acc;
          default: pc <= acc;
        endcase
      end
      // Sum and compare the powers.
      if (cmd.sum) begin
        if (sum_full[WORD_WIDTH]) begin
          ovf <= 1'b1;
        end
        eq <= !ovf && !sum_full[WORD_WIDTH] && (sum_full[WORD_WIDTH-1:0] == pc);
      end
      // Load the next GCD pair.
      if (cmd.gcd_init) begin
        case (cmd.gcd_sel)
          2'd0:    begin p <= WORD_WIDTH'(ra); q <= WORD_WIDTH'(rb); end
          2'd1:    begin p <= WORD_WIDTH'(rb); q <= WORD_WIDTH'(rc); end
          default: begin p <= WORD_WIDTH'(ra); q <= WORD_WIDTH'(rc); end
        endcase
      end
      if (cmd.gcd_swap) begin
        p <= q;
        q <= rem;
      end
      if (cmd.gcd_store && p != WORD_WIDTH'(1)) begin
        cop <= 1'b0;
      end
    end
  end

  assign stat.exp_bit  = exp_sel[bit_idx];
  assign stat.mul_busy = mul_busy || mul_pend || cmd.mul_start;
  assign stat.div_busy = div_busy || cmd.div_start;
  assign stat.q_zero   = (q == '0);

  assign equation_holds   = eq && !ovf;
  assign pairwise_coprime = cop;
  assign counterexample   = eq && !ovf && cop;
  assign overflow         = ovf;

endmodule

// ===== rtl/pscc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pscc_ctrl
// Sequencer: three powers by square-and-multiply, the sum, three GCDs.
// ----------------------------------------------------------------------------
module pscc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  pscc_pkg::stat_t stat,
  output pscc_pkg::cmd_t  cmd,
  output logic [2:0]      bit_idx,
  output logic            busy
);
  import pscc_pkg::*;

  state_t     state, state_next;
  logic [1:0] sel, sel_next;
  logic [2:0] bidx, bidx_next;
  logic       waiting, waiting_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      sel     <= '0;
      bidx    <= '0;
      waiting <= 1'b0;
    end else begin
      state   <= state_next;
      sel     <= sel_next;
      bidx    <= bidx_next;
      waiting <= waiting_next;
    end
  end

  assign bit_idx = bidx;
  assign busy    = (state != ST_IDLE);

  always_comb begin
    state_next   = state;
    sel_next     = sel;
    bidx_next    = bidx;
    waiting_next = waiting;
    cmd          = '0;
    cmd.pow_sel  = sel;
    cmd.gcd_sel  = sel;
    cmd.mop      = MOP_SQUARE;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          sel_next   = '0;
          state_next = ST_POW_INIT;
        end
      end
      ST_POW_INIT: begin
        cmd.pow_init = 1'b1;
        bidx_next    = 3'd5;
        waiting_next = 1'b0;
        state_next   = ST_POW_SQ;
      end
      // Square the accumulator.
      ST_POW_SQ: begin
        if (!waiting) begin
          cmd.mul_start = 1'b1;
          waiting_next  = 1'b1;
        end else if (!stat.mul_busy) begin
          waiting_next = 1'b0;
          state_next   = stat.exp_bit ? ST_POW_MUL : ST_POW_NEXT;
        end
      end
      // Multiply by the base when the exponent bit is set.
      ST_POW_MUL: begin
        cmd.mop = MOP_BASE;
        if (!waiting) begin
          cmd.mul_start = 1'b1;
          waiting_next  = 1'b1;
        end else if (!stat.mul_busy) begin
          waiting_next = 1'b0;
          state_next   = ST_POW_NEXT;
        end
      end
      ST_POW_NEXT: begin
        if (bidx == 3'd0) begin
          cmd.pow_store = 1'b1;
          if (sel == 2'd2) begin
            state_next = ST_SUM;
          end else begin
            sel_next   = sel + 2'd1;
            state_next = ST_POW_INIT;
          end
        end else begin
          bidx_next  = bidx - 3'd1;
          state_next = ST_POW_SQ;
        end
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        sel_next   = '0;
        state_next = ST_GCD_INIT;
      end
      ST_GCD_INIT: begin
        cmd.gcd_init = 1'b1;
        state_next   = ST_GCD_TEST;
      end
      // Finish this pair when the divisor reaches zero.
      ST_GCD_TEST: begin
        if (stat.q_zero) begin
          cmd.gcd_store = 1'b1;
          if (sel == 2'd2) begin
            state_next = ST_DONE;
          end else begin
            sel_next   = sel + 2'd1;
            state_next = ST_GCD_INIT;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_GCD_DIV;
        end
      end
      ST_GCD_DIV: begin
        if (!stat.div_busy) begin
          state_next = ST_GCD_SWAP;
        end
      end
      ST_GCD_SWAP: begin
        cmd.gcd_swap = 1'b1;
        state_next   = ST_GCD_TEST;
      end
      ST_DONE: begin
        cmd.done   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/power_sum_coprime_check_top.sv =====
// ----------------------------------------------------------------------------
// power_sum_coprime_check_top
// Checks A^x + B^y == C^z in 64 bits and pairwise coprimality of A, B, C.
// ----------------------------------------------------------------------------
// A tuple transfers at a rising edge where start is high and busy is low; one
// result follows, shown for a single cycle with done high, and the receiver
// cannot stall it. A checked 64-bit product runs as four steps on the
// 32x32 multiplier; each power squares once per exponent bit and multiplies
// once more for every set exponent bit. Then the sum is formed, and each GCD
// runs Euclid remainder steps in the bit-serial divider. The time a tuple
// takes is set mostly by the number of Euclid steps. busy stays high until
// the result cycle ends.
module power_sum_coprime_check_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [pscc_pkg::BASE_WIDTH-1:0] base_a,
  input  logic [pscc_pkg::EXP_WIDTH-1:0]  exp_x,
  input  logic [pscc_pkg::BASE_WIDTH-1:0] base_b,
  input  logic [pscc_pkg::EXP_WIDTH-1:0]  exp_y,
  input  logic [pscc_pkg::BASE_WIDTH-1:0] base_c,
  input  logic [pscc_pkg::EXP_WIDTH-1:0]  exp_z,
  output logic                            busy,
  output logic                            done,
  output logic                            equation_holds,
  output logic                            pairwise_coprime,
  output logic                            counterexample,
  output logic                            overflow
);
  import pscc_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  logic [2:0] bit_idx;
  logic       ctrl_busy;

  // Refuse a new tuple while the result is on the ports.
  pscc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start && !done),
    .stat    (stat),
    .cmd     (cmd),
    .bit_idx (bit_idx),
    .busy    (ctrl_busy)
  );

  pscc_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .bit_idx          (bit_idx),
    .base_a           (base_a),
    .exp_x            (exp_x),
    .base_b           (base_b),
    .exp_y            (exp_y),
    .base_c           (base_c),
    .exp_z            (exp_z),
    .stat             (stat),
    .done             (done),
    .equation_holds   (equation_holds),
    .pairwise_coprime (pairwise_coprime),
    .counterexample   (counterexample),
    .overflow         (overflow)
  );

  // Hold off new tuples through the result cycle.
  assign busy = ctrl_busy || done;

endmodule

// ===== tb/tb_power_sum_coprime_check_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_power_sum_coprime_check_top
// Self-checking bench for the power-sum coprime check.
// ----------------------------------------------------------------------------
// Directed tuples and 1200 random tuples are queued and sent by a
// clocked driver with random gaps. An in-bench model works out the equation,
// coprime, counterexample and overflow flags for each transfer. A clocked
// monitor compares every result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_power_sum_coprime_check_top;
  import pscc_pkg::*;

  typedef struct {
    logic [BASE_WIDTH-1:0] a, b, c;
    logic [EXP_WIDTH-1:0]  x, y, z;
    int                    gap_pct;
  } tuple_t;

  typedef struct {
    logic eq, cop, cex, ovf;
  } flags_t;

  localparam int WATCHDOG_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [BASE_WIDTH-1:0] base_a = '0, base_b = '0, base_c = '0;
  logic [EXP_WIDTH-1:0]  exp_x = '0, exp_y = '0, exp_z = '0;
  logic busy, done, equation_holds, pairwise_coprime, counterexample, overflow;

  tuple_t tuple_q[$];
  flags_t flags_q[$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  int     sent = 0;
  int     received = 0;
  int     cex_seen = 0;
  int     ovf_seen = 0;
  int     total_items = 0;
  logic   taken = 1'b0;

  power_sum_coprime_check_top uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Exact power within 64 bits; flags overflow on any oversized product.
  function automatic logic [WORD_WIDTH-1:0] exact_power(
      input logic [WORD_WIDTH-1:0] base, input logic [EXP_WIDTH-1:0] e,
      inout logic ovf);
    logic [2*WORD_WIDTH-1:0] prod;
    logic [WORD_WIDTH-1:0]   acc;
    acc = WORD_WIDTH'(1);
    for (int i = EXP_WIDTH - 1; i >= 0; i--) begin
      prod = acc * acc;
      if (prod[2*WORD_WIDTH-1:WORD_WIDTH] != '0) begin
        ovf = 1'b1;
        return '0;
      end
      acc = prod[WORD_WIDTH-1:0];
      if (e[i]) begin
        prod = acc * base;
        if (prod[2*WORD_WIDTH-1:WORD_WIDTH] != '0) begin
          ovf = 1'b1;
          return '0;
        end
        acc = prod[WORD_WIDTH-1:0];
      end
    end
    return acc;
  endfunction

  function automatic logic [WORD_WIDTH-1:0] gcd_of(
      input logic [WORD_WIDTH-1:0] p, input logic [WORD_WIDTH-1:0] q);
    logic [WORD_WIDTH-1:0] r;
    while (q != '0) begin
      r = p % q;
      p = q;
      q = r;
    end
    return p;
  endfunction

  function automatic flags_t tuple_flags(input tuple_t t);
    flags_t f;
    logic [WORD_WIDTH-1:0] pa, pb, pc;
    logic [WORD_WIDTH:0]   total;
    logic ovf;
    ovf = 1'b0;
    pa = exact_power(WORD_WIDTH'(t.a), t.x, ovf);
    pb = exact_power(WORD_WIDTH'(t.b), t.y, ovf);
    pc = exact_power(WORD_WIDTH'(t.c), t.z, ovf);
    total = pa + pb;
    if (total[WORD_WIDTH]) ovf = 1'b1;
    f.eq  = !ovf && (total[WORD_WIDTH-1:0] == pc);
    f.cop = gcd_of(WORD_WIDTH'(t.a), WORD_WIDTH'(t.b)) == WORD_WIDTH'(1) &&
            gcd_of(WORD_WIDTH'(t.b), WORD_WIDTH'(t.c)) == WORD_WIDTH'(1) &&
            gcd_of(WORD_WIDTH'(t.a), WORD_WIDTH'(t.c)) == WORD_WIDTH'(1);
    f.cex = f.eq && f.cop;
    f.ovf = ovf;
    return f;
  endfunction

  function automatic tuple_t mk(input logic [31:0] a, input int x, input logic [31:0] b,
      input int y, input logic [31:0] c, input int z, input int gap);
    tuple_t t;
    t.a = a; t.x = EXP_WIDTH'(x); t.b = b; t.y = EXP_WIDTH'(y);
    t.c = c; t.z = EXP_WIDTH'(z); t.gap_pct = gap;
    return t;
  endfunction

  // Random tuple: full range, small bases, or a constructed equality.
  function automatic tuple_t random_tuple(input int gap);
    tuple_t t;
    logic [WORD_WIDTH-1:0] s;
    int kind;
    logic ovf;
    kind = $urandom_range(0, 9);
    t.gap_pct = gap;
    t.a = $urandom; t.b = $urandom; t.c = $urandom;
    t.x = EXP_WIDTH'($urandom); t.y = EXP_WIDTH'($urandom); t.z = EXP_WIDTH'($urandom);
    if (kind < 3) begin
      t.x = EXP_WIDTH'($urandom_range(0, 3));
      t.y = EXP_WIDTH'($urandom_range(0, 3));
      t.z = EXP_WIDTH'($urandom_range(0, 3));
    end else if (kind < 6) begin
      t.a = $urandom_range(0, 50); t.b = $urandom_range(0, 50); t.c = $urandom_range(0, 50);
      t.x = EXP_WIDTH'($urandom_range(0, 8));
      t.y = EXP_WIDTH'($urandom_range(0, 8));
      t.z = EXP_WIDTH'($urandom_range(0, 8));
    end else if (kind < 9) begin
      // Build C^1 = A^x + B^y so the equation holds.
      t.a = $urandom_range(1, 2000); t.b = $urandom_range(1, 2000);
      t.x = EXP_WIDTH'($urandom_range(0, 2)); t.y = EXP_WIDTH'($urandom_range(0, 2));
      ovf = 1'b0;
      s = exact_power(WORD_WIDTH'(t.a), t.x, ovf) + exact_power(WORD_WIDTH'(t.b), t.y, ovf);
      t.c = s[BASE_WIDTH-1:0];
      t.z = EXP_WIDTH'(1);
    end
    return t;
  endfunction

  // Fill the queue of tuples to send, then release reset.
  initial begin
    int gaps[4];
    gaps = '{0, 69, 0, 11};
    tuple_q.push_back(mk(3, 2, 4, 2, 5, 2, 0));
    tuple_q.push_back(mk(7, 1, 1, 5, 2, 3, 0));
    tuple_q.push_back(mk(2, 3, 2, 3, 2, 4, 0));
    tuple_q.push_back(mk(0, 0, 0, 0, 2, 1, 0));
    tuple_q.push_back(mk(0, 5, 1, 0, 1, 7, 0));
    tuple_q.push_back(mk(0, 0, 0, 3, 0, 9, 0));
    tuple_q.push_back(mk(0, 1, 1, 1, 1, 1, 0));
    tuple_q.push_back(mk(2, 63, 2, 63, 2, 63, 0));
    tuple_q.push_back(mk(2, 62, 2, 62, 2, 63, 0));
    tuple_q.push_back(mk(3, 63, 1, 1, 1, 1, 0));
    tuple_q.push_back(mk(32'hFFFFFFFF, 2, 1, 0, 1, 0, 0));
    tuple_q.push_back(mk(32'hFFFFFFFF, 3, 1, 0, 1, 0, 0));
    tuple_q.push_back(mk(1, 63, 1, 63, 2, 1, 0));
    tuple_q.push_back(mk(32'hFFFFFFFF, 63, 32'hFFFFFFFE, 63, 32'hFFFFFFFD, 63, 0));
    tuple_q.push_back(mk(32'hFFFFFFFF, 1, 32'hFFFFFFFE, 1, 32'hFFFFFFFD, 1, 0));
    tuple_q.push_back(mk(32'h80000000, 1, 32'h80000000, 1, 1, 0, 0));
    tuple_q.push_back(mk(6, 1, 10, 1, 15, 1, 0));
    tuple_q.push_back(mk(1, 1, 1, 1, 1, 1, 0));
    tuple_q.push_back(mk(5, 0, 7, 0, 2, 1, 0));
    for (int n = 0; n < 1200; n++) tuple_q.push_back(random_tuple(gaps[n / 300]));
    total_items = tuple_q.size();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Drive the next tuple at the falling edge; hold it until it transfers.
  always @(negedge clk) begin
    if (!rst && !(start && !taken)) begin
      if (tuple_q.size() > 0 && $urandom_range(0, 99) >= tuple_q[0].gap_pct) begin
        tuple_t t;
        t = tuple_q.pop_front();
        base_a <= t.a; exp_x <= t.x;
        base_b <= t.b; exp_y <= t.y;
        base_c <= t.c; exp_z <= t.z;
        start  <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Predict on each input transfer; check each result strobe.
  always @(posedge clk) begin
    taken <= !rst && start && !busy;
    if (!rst) begin
      idle_cycles <= (done || (start && !busy)) ? 0 : idle_cycles + 1;
      if (done) begin
        received <= received + 1;
        if (flags_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result strobe at %0t", $time);
        end else begin
          flags_t e;
          e = flags_q.pop_front();
          if (e.cex) cex_seen <= cex_seen + 1;
          if (e.ovf) ovf_seen <= ovf_seen + 1;
          if ({equation_holds, pairwise_coprime, counterexample, overflow} !==
              {e.eq, e.cop, e.cex, e.ovf}) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch at %0t: eq/cop/cex/ovf expected %b%b%b%b got %b%b%b%b",
                       $time, e.eq, e.cop, e.cex, e.ovf, equation_holds,
                       pairwise_coprime, counterexample, overflow);
          end
        end
      end
      if (start && !busy) begin
        tuple_t t;
        t = mk(base_a, exp_x, base_b, exp_y, base_c, exp_z, 0);
        flags_q.push_back(tuple_flags(t));
        sent <= sent + 1;
      end
    end
  end

  // Stop the run if nothing transfers for too long.
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("tb_power_sum_coprime_check_top failed");
      $finish;
    end
  end

  // Wait for the last result, let the block settle, then report.
  initial begin
    wait (!rst);
    wait (received >= total_items);
    repeat (200) @(posedge clk);
    $display("sent %0d tuples, checked %0d results (%0d counterexamples, %0d overflows)",
             sent, received, cex_seen, ovf_seen);
    $display("gap phases: none, 69 percent, none, 11 percent; %0d mismatches", mismatches);
    if (mismatches == 0 && flags_q.size() == 0 && sent == total_items &&
        received == total_items)
      $display("tb_power_sum_coprime_check_top passed");
    else
      $display("tb_power_sum_coprime_check_top failed");
    $finish;
  end

endmodule
